>>> sv/brcmm_pkg.sv
`default_nettype none
package brcmm_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Pipeline depth: error, product, moment, partials, torque, pair sums, output
  localparam int unsigned NUM_STAGES = 7;

  // Intermediates saturate symmetrically at +-(2^62 - 1)
  localparam int unsigned SAT_W  = 63;
  localparam int unsigned WIDE_W = 128;
  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((64'sd1 <<< 62) - 64'sd1);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI;

  // Quarter of the mix sum
  localparam int unsigned MIX_SHIFT = 2;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_ROLL  = 3'd0,
    CFG_GAIN_PITCH = 3'd1,
    CFG_GAIN_YAW   = 3'd2,
    CFG_INV_ARM    = 3'd3,
    CFG_INV_DRAG   = 3'd4,
    CFG_MIN_THRUST = 3'd5,
    CFG_MAX_THRUST = 3'd6
  } cfg_idx_e;

  // Width of a moment after the first product, shift and saturation
  function automatic int unsigned moment_width(input int unsigned dw, input int unsigned fb);
    int unsigned raw;
    raw = 2 * dw + 1 - fb;
    return (raw > SAT_W) ? SAT_W : raw;
  endfunction

  // Width of a scaled torque; the moment gets one extra bit for negation
  function automatic int unsigned torque_width(input int unsigned dw, input int unsigned fb);
    int unsigned raw;
    raw = moment_width(dw, fb) + 1 + dw - fb;
    return (raw > SAT_W) ? SAT_W : raw;
  endfunction

  function automatic logic signed [SAT_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] clipped;
    if (x > SAT_HI) begin
      clipped = SAT_HI;
    end else if (x < SAT_LO) begin
      clipped = SAT_LO;
    end else begin
      clipped = x;
    end
    return SAT_W'(clipped);
  endfunction

endpackage
`default_nettype wire

>>> sv/brcmm_axis.sv
`default_nettype none
module brcmm_axis #(
  parameter int unsigned DATA_WIDTH = brcmm_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = brcmm_pkg::FRAC_BITS_DEF,
  parameter bit          NEG_MOMENT = 1'b0
) (
  input  wire  logic                                  clk_i,
  input  wire  logic [3:0]                            stage_en_i,
  input  wire  logic signed [DATA_WIDTH-1:0]          gain_i,
  input  wire  logic signed [DATA_WIDTH:0]            err_i,
  input  wire  logic [DATA_WIDTH-2:0]                 inv_i,
  output logic signed
    [brcmm_pkg::torque_width(DATA_WIDTH, FRAC_BITS)-1:0] torque_o
);
  import brcmm_pkg::*;

  localparam int unsigned P1W   = 2 * DATA_WIDTH + 1;
  localparam int unsigned MW    = moment_width(DATA_WIDTH, FRAC_BITS);
  localparam int unsigned NW    = MW + 1;
  localparam int unsigned LOW_W = NW / 2;
  localparam int unsigned HI_W  = NW - LOW_W;
  localparam int unsigned PHW   = HI_W + DATA_WIDTH;
  localparam int unsigned PLW   = LOW_W + 1 + DATA_WIDTH;
  localparam int unsigned P2W   = NW + DATA_WIDTH;
  localparam int unsigned TW    = torque_width(DATA_WIDTH, FRAC_BITS);

  logic signed [P1W-1:0]        prod_d, prod_q;
  logic signed [P1W-1:0]        prod_sh;
  logic signed [SAT_W-1:0]      mom_sat;
  logic signed [NW-1:0]         mom_ext;
  logic signed [NW-1:0]         mom_d, mom_q;
  logic [LOW_W-1:0]             mom_lo;
  logic signed [HI_W-1:0]       mom_hi;
  logic signed [DATA_WIDTH-1:0] inv_s;
  logic signed [PHW-1:0]        ph_d, ph_q;
  logic signed [PLW-1:0]        pl_d, pl_q;
  logic signed [P2W-1:0]        p2_sum, p2_sh;
  logic signed [SAT_W-1:0]      trq_sat;
  logic signed [TW-1:0]         trq_d, trq_q;

  // Gain times rate error, exact
  assign prod_d = P1W'(gain_i) * P1W'(err_i);

  // Floor shift, saturate, optional negation (yaw)
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign mom_sat = sat_wide(WIDE_W'(prod_sh));
  assign mom_ext = NW'($signed(mom_sat[MW-1:0]));
  assign mom_d   = NEG_MOMENT ? -mom_ext : mom_ext;

  // Moment times reciprocal, split in two partial products
  assign mom_lo = mom_q[LOW_W-1:0];
  assign mom_hi = $signed(mom_q[NW-1:LOW_W]);
  assign inv_s  = $signed({1'b0, inv_i});
  assign ph_d   = PHW'(mom_hi) * PHW'(inv_s);
  assign pl_d   = PLW'($signed({1'b0, mom_lo})) * PLW'(inv_s);

  assign p2_sum  = (P2W'(ph_q) <<< LOW_W) + P2W'(pl_q);
  assign p2_sh   = p2_sum >>> FRAC_BITS;
  assign trq_sat = sat_wide(WIDE_W'(p2_sh));
  assign trq_d   = $signed(trq_sat[TW-1:0]);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      prod_q <= prod_d;
    end
    if (stage_en_i[1]) begin
      mom_q <= mom_d;
    end
    if (stage_en_i[2]) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
    if (stage_en_i[3]) begin
      trq_q <= trq_d;
    end
  end

  assign torque_o = trq_q;

endmodule
`default_nettype wire

>>> sv/body_rate_control_motor_mixer.sv
// Body-rate P controller with X-frame motor mixer.
// Input channel (in_valid_i/in_ready_o): collective thrust plus commanded and
// measured roll, pitch and yaw rates, all signed fixed point. Output channel
// (out_valid_o/out_ready_i): four motor thrusts, clamped to
// [min_thrust, max_thrust]. One result per input transfer, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (gains, reciprocal arm length and drag ratio, thrust limits); index 7 is
// ignored. Write only while the pipeline is empty.
// Pipeline: an input transfer passes through seven register stages (error,
// gain product, moment, split reciprocal product, torque, pair sums, clamped
// output) before out_valid_o rises. Throughput: one item per cycle while
// the receiver keeps out_ready_i high.
// Stall: a full stage holds while the one after it holds, so
// bubbles collapse; in_ready_o drops only when all stages are full and the
// receiver holds off. Nothing is dropped or repeated.
// Reset: empties the pipeline and loads the register defaults (gains 0,
// reciprocals 1.0, min 0, max 100.0).
`default_nettype none
module body_rate_control_motor_mixer #(
  parameter int unsigned DATA_WIDTH = brcmm_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = brcmm_pkg::FRAC_BITS_DEF
) (
  input  wire  logic                                clk_i,
  input  wire  logic                                rst_ni,
  input  wire  logic                                cfg_we_i,
  input  wire  logic [brcmm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  logic [DATA_WIDTH-1:0]               cfg_wdata_i,
  input  wire  logic                                in_valid_i,
  output logic                                      in_ready_o,
  input  wire  logic signed [DATA_WIDTH-1:0]        collective_thrust_i,
  input  wire  logic signed [DATA_WIDTH-1:0]        rate_cmd_roll_i,
  input  wire  logic signed [DATA_WIDTH-1:0]        rate_cmd_pitch_i,
  input  wire  logic signed [DATA_WIDTH-1:0]        rate_cmd_yaw_i,
  input  wire  logic signed [DATA_WIDTH-1:0]        rate_meas_roll_i,
  input  wire  logic signed [DATA_WIDTH-1:0]        rate_meas_pitch_i,
  input  wire  logic signed [DATA_WIDTH-1:0]        rate_meas_yaw_i,
  output logic                                      out_valid_o,
  input  wire  logic                                out_ready_i,
  output logic signed [DATA_WIDTH-1:0]              thrust_slot0_o,
  output logic signed [DATA_WIDTH-1:0]              thrust_slot1_o,
  output logic signed [DATA_WIDTH-1:0]              thrust_slot2_o,
  output logic signed [DATA_WIDTH-1:0]              thrust_slot3_o
);
  import brcmm_pkg::*;

  localparam int unsigned TW   = torque_width(DATA_WIDTH, FRAC_BITS);
  localparam int unsigned MAXW = (TW > DATA_WIDTH) ? TW : DATA_WIDTH;
  localparam int unsigned SUMW = MAXW + 2;
  localparam int unsigned NS   = NUM_STAGES;

  localparam logic [DATA_WIDTH-2:0] INV_RST =
    (DATA_WIDTH - 1)'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_WIDTH-1:0] MAX_RST =
    DATA_WIDTH'(64'd100 << FRAC_BITS);

  // Configuration registers
  logic signed [DATA_WIDTH-1:0] gain_roll_q, gain_pitch_q, gain_yaw_q;
  logic [DATA_WIDTH-2:0]        inv_arm_q, inv_drag_q;
  logic signed [DATA_WIDTH-1:0] min_thrust_q, max_thrust_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_roll_q  <= '0;
      gain_pitch_q <= '0;
      gain_yaw_q   <= '0;
      inv_arm_q    <= INV_RST;
      inv_drag_q   <= INV_RST;
      min_thrust_q <= '0;
      max_thrust_q <= MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_ROLL:  gain_roll_q  <= $signed(cfg_wdata_i);
        CFG_GAIN_PITCH: gain_pitch_q <= $signed(cfg_wdata_i);
        CFG_GAIN_YAW:   gain_yaw_q   <= $signed(cfg_wdata_i);
        CFG_INV_ARM:    inv_arm_q    <= cfg_wdata_i[DATA_WIDTH-2:0];
        CFG_INV_DRAG:   inv_drag_q   <= cfg_wdata_i[DATA_WIDTH-2:0];
        CFG_MIN_THRUST: min_thrust_q <= $signed(cfg_wdata_i);
        CFG_MAX_THRUST: max_thrust_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or the next one moves
  logic [NS:1]   valid_q;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: rate errors
  logic signed [DATA_WIDTH:0]   err_x_q, err_y_q, err_z_q;
  logic signed [DATA_WIDTH-1:0] thr_q [1:5];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      err_x_q  <= (DATA_WIDTH + 1)'(rate_cmd_roll_i)  - (DATA_WIDTH + 1)'(rate_meas_roll_i);
      err_y_q  <= (DATA_WIDTH + 1)'(rate_cmd_pitch_i) - (DATA_WIDTH + 1)'(rate_meas_pitch_i);
      err_z_q  <= (DATA_WIDTH + 1)'(rate_cmd_yaw_i)   - (DATA_WIDTH + 1)'(rate_meas_yaw_i);
      thr_q[1] <= collective_thrust_i;
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        thr_q[k] <= thr_q[k-1];
      end
    end
  end

  // Stages 2..5: per-axis moment and scaled torque
  logic signed [TW-1:0] tx, ty, tz;

  brcmm_axis #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .NEG_MOMENT (1'b0)
  ) u_axis_roll (
    .clk_i      (clk_i),
    .stage_en_i (en[5:2]),
    .gain_i     (gain_roll_q),
    .err_i      (err_x_q),
    .inv_i      (inv_arm_q),
    .torque_o   (tx)
  );

  brcmm_axis #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .NEG_MOMENT (1'b0)
  ) u_axis_pitch (
    .clk_i      (clk_i),
    .stage_en_i (en[5:2]),
    .gain_i     (gain_pitch_q),
    .err_i      (err_y_q),
    .inv_i      (inv_arm_q),
    .torque_o   (ty)
  );

  // Yaw torque uses the negated moment
  brcmm_axis #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .NEG_MOMENT (1'b1)
  ) u_axis_yaw (
    .clk_i      (clk_i),
    .stage_en_i (en[5:2]),
    .gain_i     (gain_yaw_q),
    .err_i      (err_z_q),
    .inv_i      (inv_drag_q),
    .torque_o   (tz)
  );

  // Stage 6: pair sums. slot0 = a+c, slot1 = b+d, slot2 = a-c, slot3 = b-d
  logic signed [SUMW-1:0] pa_q, pb_q, pc_q, pd_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pa_q <= SUMW'(thr_q[5]) + SUMW'(tx);
      pb_q <= SUMW'(thr_q[5]) - SUMW'(tx);
      pc_q <= SUMW'(ty) + SUMW'(tz);
      pd_q <= SUMW'(ty) - SUMW'(tz);
    end
  end

  // Stage 7: quarter with floor, then clamp (lower limit tested first)
  logic signed [SUMW-1:0]       mix_sum [4];
  logic signed [SUMW-1:0]       mix_q   [4];
  logic signed [DATA_WIDTH-1:0] slot_d  [4];
  logic signed [DATA_WIDTH-1:0] slot_q  [4];
  logic signed [SUMW-1:0]       lo_ext, hi_ext;

  assign lo_ext = SUMW'(min_thrust_q);
  assign hi_ext = SUMW'(max_thrust_q);

  always_comb begin
    mix_sum[0] = pa_q + pc_q;
    mix_sum[1] = pb_q + pd_q;
    mix_sum[2] = pa_q - pc_q;
    mix_sum[3] = pb_q - pd_q;
    for (int s = 0; s < 4; s++) begin
      mix_q[s] = mix_sum[s] >>> MIX_SHIFT;
      if (mix_q[s] < lo_ext) begin
        slot_d[s] = min_thrust_q;
      end else if (mix_q[s] > hi_ext) begin
        slot_d[s] = max_thrust_q;
      end else begin
        slot_d[s] = DATA_WIDTH'(mix_q[s]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      for (int s = 0; s < 4; s++) begin
        slot_q[s] <= slot_d[s];
      end
    end
  end

  assign out_valid_o    = valid_q[NS];
  assign thrust_slot0_o = slot_q[0];
  assign thrust_slot1_o = slot_q[1];
  assign thrust_slot2_o = slot_q[2];
  assign thrust_slot3_o = slot_q[3];

endmodule
`default_nettype wire

>>> sv/brcmm_checker.sv
`default_nettype none
module brcmm_checker #(
  parameter int unsigned DATA_WIDTH = brcmm_pkg::DATA_WIDTH_DEF
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [DATA_WIDTH-1:0]  thrust_slot0_o,
  input wire logic [DATA_WIDTH-1:0]  thrust_slot1_o,
  input wire logic [DATA_WIDTH-1:0]  thrust_slot2_o,
  input wire logic [DATA_WIDTH-1:0]  thrust_slot3_o
);

  // Held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(thrust_slot0_o)
      && $stable(thrust_slot1_o) && $stable(thrust_slot2_o) && $stable(thrust_slot3_o))
    else $error("held output changed before transfer");

  // With no result waiting, the pipeline has room
  a_ready_when_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage empty");

  // A ready receiver lets the whole pipeline advance
  a_ready_follows_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while receiver ready");

  // Pipeline comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind body_rate_control_motor_mixer brcmm_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_brcmm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .thrust_slot0_o (thrust_slot0_o),
  .thrust_slot1_o (thrust_slot1_o),
  .thrust_slot2_o (thrust_slot2_o),
  .thrust_slot3_o (thrust_slot3_o)
);
`default_nettype wire
